// ===== design/spt_pkg.sv =====
// Package for the sensor pulse trigger: shared widths, register indexes,
// the configuration struct and the result struct. No dependencies.

package spt_pkg;

    localparam int STATE_W    = 32;   // bits of the state word that are tracked
    localparam int STATE_IN_W = 32;   // width of the state field on the input
    localparam int PERIOD_W   = 16;
    localparam int TICK_W     = PERIOD_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 40;   // 34 payload bits padded to whole bytes
    localparam int M_DATA_W   = 8;    // 3 payload bits padded to a byte

    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_ENABLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DETECTOR_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUSPENDED     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_TARGETS   = 3'd6;

    localparam logic [1:0] MODE_EDGE_ONLY = 2'd0;

    typedef struct packed {
        logic [PERIOD_W-1:0] repeat_period;
        logic [1:0]          pulse_mode;
        logic                invert_level;
        logic                tap_enable;
        logic                detector_mode;
        logic                suspended;
        logic                has_targets;
    } spt_cfg_t;

    typedef struct packed {
        logic level_on;
        logic fire_value;
        logic fire;
    } spt_res_t;

endpackage

// ===== design/spt_core.sv =====
// Sensor state and per-item update logic of the sensor pulse trigger.
// Depends on spt_pkg for the configuration and result structs.

module spt_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  spt_pkg::spt_cfg_t              cfg,
    input  logic                           step,
    input  logic                           active,
    input  logic [spt_pkg::STATE_IN_W-1:0] state_id,
    input  logic                           raw_detect,
    output spt_pkg::spt_res_t              res
);

    logic [spt_pkg::STATE_W-1:0] prev_state_reg, prev_state_next;
    logic                        prev_valid_reg, prev_valid_next;
    logic                        first_run_reg, first_run_next;
    logic                        level_reg, level_next;
    logic [spt_pkg::TICK_W-1:0]  tick_count_reg, tick_count_next;
    logic                        tap_armed_reg, tap_armed_next;
    logic                        tap_release_reg, tap_release_next;
    logic                        pulse_on_reg, pulse_on_next;

    logic [spt_pkg::STATE_W-1:0] sid;
    logic                        changed;
    logic                        runs;
    logic                        tap_mode;
    logic [spt_pkg::TICK_W-1:0]  tick_inc;
    logic                        fr, lvl, arm, det, query, edge_seen, q, fire;

    assign sid      = state_id[spt_pkg::STATE_W-1:0];
    assign changed  = !prev_valid_reg || (prev_state_reg != sid);
    assign runs     = active && !cfg.suspended && cfg.has_targets;
    assign tap_mode = cfg.tap_enable && !cfg.pulse_mode[0];
    assign tick_inc = tick_count_reg + spt_pkg::TICK_W'(1);

    always_comb begin
        prev_state_next  = prev_state_reg;
        prev_valid_next  = prev_valid_reg;
        first_run_next   = first_run_reg;
        level_next       = level_reg;
        tick_count_next  = tick_count_reg;
        tap_armed_next   = tap_armed_reg;
        tap_release_next = tap_release_reg;
        pulse_on_next    = pulse_on_reg;
        fr        = first_run_reg;
        lvl       = level_reg;
        arm       = tap_armed_reg;
        det       = 1'b0;
        query     = 1'b0;
        edge_seen = 1'b0;
        q         = 1'b0;
        fire      = 1'b0;

        if (!active) begin
            if (changed) begin
                prev_state_next = sid;
                prev_valid_next = 1'b1;
                first_run_next  = 1'b1;
                level_next      = 1'b0;
                tap_armed_next  = 1'b1;
            end
        end else if (runs) begin
            // A state change restarts the sensor before the query decision.
            if (changed) begin
                fr  = 1'b1;
                lvl = 1'b0;
                arm = 1'b1;
                det = cfg.detector_mode;
                prev_state_next = sid;
                prev_valid_next = 1'b1;
            end
            first_run_next = fr;
            level_next     = lvl;
            tap_armed_next = arm;

            query = fr || (tick_inc > {1'b0, cfg.repeat_period})
                    || (cfg.pulse_mode == spt_pkg::MODE_EDGE_ONLY);
            tick_count_next = query ? '0 : tick_inc;

            if (query) begin
                edge_seen  = lvl != raw_detect;
                level_next = raw_detect;
                if (cfg.pulse_mode == spt_pkg::MODE_EDGE_ONLY) begin
                    fire = edge_seen;
                end else if (cfg.pulse_mode[1]) begin
                    fire = edge_seen || (raw_detect == cfg.invert_level);
                end else begin
                    fire = edge_seen || (raw_detect != cfg.invert_level);
                end

                if (tap_mode) begin
                    q             = raw_detect != cfg.invert_level;
                    fire          = 1'b0;
                    pulse_on_next = 1'b0;
                    if (arm && q) begin
                        fire             = 1'b1;
                        level_next       = 1'b1;
                        pulse_on_next    = 1'b1;
                        tap_armed_next   = 1'b0;
                        tap_release_next = 1'b1;
                    end else if (tap_release_reg) begin
                        level_next       = 1'b0;
                        fire             = 1'b1;
                        tap_release_next = 1'b0;
                    end else begin
                        level_next     = 1'b0;
                        tap_armed_next = arm || !q;
                    end
                end else begin
                    pulse_on_next = raw_detect ^ cfg.invert_level;
                end

                if (fr) begin
                    first_run_next = 1'b0;
                    if (cfg.invert_level) begin
                        fire = 1'b1;
                    end
                end
                if (det) begin
                    fire = 1'b1;
                end
            end
        end

        res.fire       = fire;
        res.fire_value = fire && (tap_mode ? level_next : (level_next ^ cfg.invert_level));
        res.level_on   = pulse_on_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_state_reg  <= '0;
            prev_valid_reg  <= 1'b0;
            first_run_reg   <= 1'b1;
            level_reg       <= 1'b0;
            tick_count_reg  <= '0;
            tap_armed_reg   <= 1'b1;
            tap_release_reg <= 1'b0;
            pulse_on_reg    <= 1'b0;
        end else if (step) begin
            prev_state_reg  <= prev_state_next;
            prev_valid_reg  <= prev_valid_next;
            first_run_reg   <= first_run_next;
            level_reg       <= level_next;
            tick_count_reg  <= tick_count_next;
            tap_armed_reg   <= tap_armed_next;
            tap_release_reg <= tap_release_next;
            pulse_on_reg    <= pulse_on_next;
        end
    end

    // Any accepted item that is inactive or running leaves a recorded state behind it.
    a_state_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (!active || runs) |=> prev_valid_reg)
        else $error("state word not recorded after item");

    // Detector mode must fire on a state change seen while running.
    a_detector_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        step && runs && changed && cfg.detector_mode |-> res.fire)
        else $error("detector mode missed a state change");

    // A reported value of one only travels with a pulse.
    a_value_needs_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        res.fire_value |-> res.fire)
        else $error("fire_value set without fire");

    // Sensor state moves only when an item is taken.
    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(tick_count_reg) && $stable(pulse_on_reg) && $stable(prev_state_reg))
        else $error("sensor state changed without an item");

endmodule

// ===== design/spt_outbuf.sv =====
// Two-entry result buffer (output register plus skid register) of the
// sensor pulse trigger. Depends on spt_pkg for the result struct.

module spt_outbuf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  spt_pkg::spt_res_t in_res,
    output logic              out_valid,
    input  logic              out_ready,
    output spt_pkg::spt_res_t out_res
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    spt_pkg::spt_res_t out_res_reg, out_res_next;
    spt_pkg::spt_res_t skid_res_reg, skid_res_next;
    logic              push, out_free;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_res_next   = in_res;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    // The skid entry is always the younger one.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    // An item arriving while the output stalls is parked in the skid entry.
    a_park_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        push && out_valid_reg && !out_ready |=> skid_valid_reg)
        else $error("item lost while output stalled");

    // A parked item keeps its value until it moves up.
    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !out_ready |=> skid_valid_reg && $stable(skid_res_reg))
        else $error("parked item changed");

endmodule

// ===== design/sensor_pulse_trigger.sv =====
// Sensor pulse trigger: turns a raw detect bit into pulse strobes. Each
// accepted item is processed in the cycle it is taken and produces exactly
// one result item, registered in the output buffer. One item is taken per
// clock while the skid entry is empty; the two-entry result buffer lets it
// keep taking items while one result is stalled. Configuration is written
// by the user through cfg_wen/cfg_index/cfg_wdata only while idle; the
// block does not enforce it. Depends on spt_pkg, spt_core and spt_outbuf.

module sensor_pulse_trigger (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wen,
    input  logic [spt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Bits from 0: active, state_id[31:0], raw_detect, zero padding.
    input  logic [spt_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Bits from 0: fire, fire_value, level_on, zero padding.
    output logic [spt_pkg::M_DATA_W-1:0]     m_tdata
);

    spt_pkg::spt_cfg_t cfg_reg;
    spt_pkg::spt_res_t core_res, buf_res;
    logic              step;

    assign step = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.repeat_period <= '0;
            cfg_reg.pulse_mode    <= spt_pkg::MODE_EDGE_ONLY;
            cfg_reg.invert_level  <= 1'b0;
            cfg_reg.tap_enable    <= 1'b0;
            cfg_reg.detector_mode <= 1'b0;
            cfg_reg.suspended     <= 1'b0;
            cfg_reg.has_targets   <= 1'b1;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                spt_pkg::REG_REPEAT_PERIOD:
                    cfg_reg.repeat_period <= cfg_wdata[spt_pkg::PERIOD_W-1:0];
                spt_pkg::REG_PULSE_MODE:    cfg_reg.pulse_mode    <= cfg_wdata[1:0];
                spt_pkg::REG_INVERT_LEVEL:  cfg_reg.invert_level  <= cfg_wdata[0];
                spt_pkg::REG_TAP_ENABLE:    cfg_reg.tap_enable    <= cfg_wdata[0];
                spt_pkg::REG_DETECTOR_MODE: cfg_reg.detector_mode <= cfg_wdata[0];
                spt_pkg::REG_SUSPENDED:     cfg_reg.suspended     <= cfg_wdata[0];
                spt_pkg::REG_HAS_TARGETS:   cfg_reg.has_targets   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    spt_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .step       (step),
        .active     (s_tdata[0]),
        .state_id   (s_tdata[spt_pkg::STATE_IN_W:1]),
        .raw_detect (s_tdata[spt_pkg::STATE_IN_W+1]),
        .res        (core_res)
    );

    spt_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_res    (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (buf_res)
    );

    assign m_tdata = {{(spt_pkg::M_DATA_W-3){1'b0}},
                      buf_res.level_on, buf_res.fire_value, buf_res.fire};

endmodule
